// ===== rtl/core/blle_pkg.sv =====
// Shared types and constants for the bounded linked list engine.
package blle_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 2;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_PAD_W    = OUT_TDATA_W - VALUE_W - STATUS_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_DELETE     = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Selects the slot address that is read in the next cycle.
  typedef enum logic [1:0] {
    CUR_HOLD = 2'd0,
    CUR_HEAD = 2'd1,
    CUR_TAIL = 2'd2,
    CUR_FWD  = 2'd3
  } cur_sel_t;

  typedef struct packed {
    logic     capture;
    logic     push_alloc;
    logic     push_link;
    logic     del_head;
    logic     del_tail;
    logic     del_mid;
    logic     clear;
    cur_sel_t cur_sel;
    logic     step_clr;
    logic     step_inc;
    logic     emit_status;
    logic     emit_item;
    status_t  status;
  } blle_cmd_t;

  typedef struct packed {
    op_t  op;
    logic count_zero;
    logic full;
    logic match;
    logic last_step;
    logic out_free;
  } blle_stat_t;

endpackage

// ===== rtl/core/blle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module blle_ram #(
  parameter int WIDTH = blle_pkg::VALUE_W,
  parameter int DEPTH = blle_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/blle_dp.sv =====
// Datapath: slot memories, free map, head and tail pointers, walk counter, output register.
module blle_dp #(
  parameter int CAPACITY = blle_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [blle_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  blle_pkg::blle_cmd_t                 cmd,
  output blle_pkg::blle_stat_t                stat,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [blle_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = blle_pkg::VALUE_W;
  localparam int OW = blle_pkg::OP_W;

  blle_pkg::op_t          op_q;
  logic signed [VW-1:0]   value_q;
  logic [IW-1:0]          head;
  logic [IW-1:0]          tail;
  logic [CW-1:0]          count;
  logic [CAPACITY-1:0]    free_map;
  logic [IW-1:0]          cur;
  logic [IW-1:0]          cur_next;
  logic [CW-1:0]          n;
  logic [IW-1:0]          new_slot;
  logic [IW-1:0]          free_slot;

  logic [VW-1:0]          val_rd;
  logic [IW-1:0]          fwd_rd;
  logic [IW-1:0]          bwd_rd;
  logic                   fwd_we;
  logic [IW-1:0]          fwd_waddr;
  logic [IW-1:0]          fwd_wdata;
  logic                   bwd_we;
  logic [IW-1:0]          bwd_waddr;
  logic [IW-1:0]          bwd_wdata;

  blle_pkg::status_t      out_status;
  logic signed [VW-1:0]   out_item;

  logic is_front;
  logic count_one;

  assign is_front  = (op_q == blle_pkg::OP_PUSH_FRONT);
  assign count_one = (count == CW'(1));

  // Lowest-numbered free slot takes the next entry.
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_slot = IW'(i);
      end
    end
  end

  always_comb begin
    unique case (cmd.cur_sel)
      blle_pkg::CUR_HOLD: cur_next = cur;
      blle_pkg::CUR_HEAD: cur_next = head;
      blle_pkg::CUR_TAIL: cur_next = tail;
      blle_pkg::CUR_FWD:  cur_next = fwd_rd;
      default:            cur_next = cur;
    endcase
  end

  // Forward link writes.
  always_comb begin
    fwd_we    = 1'b0;
    fwd_waddr = free_slot;
    fwd_wdata = '0;
    if (cmd.push_alloc) begin
      fwd_we    = 1'b1;
      fwd_waddr = free_slot;
      fwd_wdata = (is_front && count != '0) ? head : '0;
    end else if (cmd.push_link && !is_front) begin
      fwd_we    = 1'b1;
      fwd_waddr = tail;
      fwd_wdata = new_slot;
    end else if (cmd.del_tail) begin
      fwd_we    = 1'b1;
      fwd_waddr = bwd_rd;
      fwd_wdata = '0;
    end else if (cmd.del_mid) begin
      fwd_we    = 1'b1;
      fwd_waddr = bwd_rd;
      fwd_wdata = fwd_rd;
    end
  end

  // Backward link writes.
  always_comb begin
    bwd_we    = 1'b0;
    bwd_waddr = free_slot;
    bwd_wdata = '0;
    if (cmd.push_alloc) begin
      bwd_we    = 1'b1;
      bwd_waddr = free_slot;
      bwd_wdata = (!is_front && count != '0) ? tail : '0;
    end else if (cmd.push_link && is_front) begin
      bwd_we    = 1'b1;
      bwd_waddr = head;
      bwd_wdata = new_slot;
    end else if (cmd.del_head) begin
      bwd_we    = 1'b1;
      bwd_waddr = fwd_rd;
      bwd_wdata = '0;
    end else if (cmd.del_mid) begin
      bwd_we    = 1'b1;
      bwd_waddr = fwd_rd;
      bwd_wdata = bwd_rd;
    end
  end

  blle_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (cmd.push_alloc),
    .waddr (free_slot),
    .wdata (value_q),
    .raddr (cur_next),
    .rdata (val_rd)
  );

  blle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .raddr (cur_next),
    .rdata (fwd_rd)
  );

  blle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_bwd_ram (
    .clk   (clk),
    .we    (bwd_we),
    .waddr (bwd_waddr),
    .wdata (bwd_wdata),
    .raddr (cur_next),
    .rdata (bwd_rd)
  );

  // List bookkeeping and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      free_map <= '1;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.push_alloc) begin
        free_map[free_slot] <= 1'b0;
        count               <= count + CW'(1);
        if (count == '0) begin
          head <= free_slot;
          tail <= free_slot;
        end
      end else if (cmd.push_link) begin
        if (is_front) begin
          head <= new_slot;
        end else begin
          tail <= new_slot;
        end
      end else if (cmd.del_head || cmd.del_tail || cmd.del_mid) begin
        free_map[cur] <= 1'b1;
        count         <= count - CW'(1);
        if (count_one) begin
          head <= '0;
          tail <= '0;
        end else if (cmd.del_head) begin
          head <= fwd_rd;
        end else if (cmd.del_tail) begin
          tail <= bwd_rd;
        end
      end else if (cmd.clear) begin
        free_map <= '1;
        count    <= '0;
        head     <= '0;
        tail     <= '0;
      end

      if (cmd.emit_status || cmd.emit_item) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= blle_pkg::op_t'(s_tdata[OW-1:0]);
      value_q <= s_tdata[OW+VW-1:OW];
    end
    if (cmd.push_alloc) begin
      new_slot <= free_slot;
    end
    cur <= cur_next;
    if (cmd.step_clr) begin
      n <= '0;
    end else if (cmd.step_inc) begin
      n <= n + CW'(1);
    end
    if (cmd.emit_status) begin
      out_status <= cmd.status;
      out_item   <= '0;
      m_tlast    <= 1'b1;
    end else if (cmd.emit_item) begin
      out_status <= blle_pkg::ST_OK;
      out_item   <= val_rd;
      m_tlast    <= stat.last_step;
    end
  end

  assign m_tdata = {{blle_pkg::OUT_PAD_W{1'b0}}, out_item, out_status};

  assign stat.op         = op_q;
  assign stat.count_zero = (count == '0);
  assign stat.full       = (count >= CW'(CAPACITY));
  assign stat.match      = (val_rd == value_q);
  assign stat.last_step  = ((n + CW'(1)) == count);
  assign stat.out_free   = !m_tvalid || m_tready;

endmodule

// ===== rtl/core/blle_ctrl.sv =====
// Controller: sequences each operation and drives datapath commands.
module blle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  blle_pkg::blle_stat_t stat,
  output blle_pkg::blle_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH_LINK,
    S_DEL_HEAD,
    S_DEL_TAIL,
    S_DEL_SRCH,
    S_DUMP,
    S_EMIT
  } state_t;

  state_t            state;
  state_t            state_next;
  blle_pkg::status_t code;
  blle_pkg::status_t code_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= blle_pkg::ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.cur_sel = blle_pkg::CUR_HOLD;
    cmd.status  = blle_pkg::ST_OK;
    state_next  = state;
    code_next   = code;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.op) inside
          blle_pkg::OP_PUSH_FRONT, blle_pkg::OP_PUSH_BACK: begin
            if (stat.full) begin
              code_next  = blle_pkg::ST_FULL;
              state_next = S_EMIT;
            end else begin
              cmd.push_alloc = 1'b1;
              code_next      = blle_pkg::ST_OK;
              state_next     = stat.count_zero ? S_EMIT : S_PUSH_LINK;
            end
          end
          blle_pkg::OP_DELETE: begin
            if (stat.count_zero) begin
              code_next  = blle_pkg::ST_EMPTY;
              state_next = S_EMIT;
            end else begin
              cmd.cur_sel = blle_pkg::CUR_HEAD;
              state_next  = S_DEL_HEAD;
            end
          end
          blle_pkg::OP_CLEAR: begin
            if (stat.count_zero) begin
              code_next = blle_pkg::ST_EMPTY;
            end else begin
              cmd.clear = 1'b1;
              code_next = blle_pkg::ST_OK;
            end
            state_next = S_EMIT;
          end
          blle_pkg::OP_DUMP: begin
            if (stat.count_zero) begin
              code_next  = blle_pkg::ST_EMPTY;
              state_next = S_EMIT;
            end else begin
              cmd.cur_sel  = blle_pkg::CUR_HEAD;
              cmd.step_clr = 1'b1;
              state_next   = S_DUMP;
            end
          end
          default: begin
            // Unused op codes give no result.
            state_next = S_IDLE;
          end
        endcase
      end
      S_PUSH_LINK: begin
        cmd.push_link = 1'b1;
        state_next    = S_EMIT;
      end
      S_DEL_HEAD: begin
        if (stat.match) begin
          cmd.del_head = 1'b1;
          code_next    = blle_pkg::ST_OK;
          state_next   = S_EMIT;
        end else begin
          cmd.cur_sel = blle_pkg::CUR_TAIL;
          state_next  = S_DEL_TAIL;
        end
      end
      S_DEL_TAIL: begin
        if (stat.match) begin
          cmd.del_tail = 1'b1;
          code_next    = blle_pkg::ST_OK;
          state_next   = S_EMIT;
        end else begin
          cmd.cur_sel  = blle_pkg::CUR_HEAD;
          cmd.step_clr = 1'b1;
          state_next   = S_DEL_SRCH;
        end
      end
      S_DEL_SRCH: begin
        if (stat.match) begin
          cmd.del_mid = 1'b1;
          code_next   = blle_pkg::ST_OK;
          state_next  = S_EMIT;
        end else if (stat.last_step) begin
          code_next  = blle_pkg::ST_NOT_FOUND;
          state_next = S_EMIT;
        end else begin
          cmd.step_inc = 1'b1;
          cmd.cur_sel  = blle_pkg::CUR_FWD;
        end
      end
      S_DUMP: begin
        // The read address holds on the current entry while the output is stalled.
        if (stat.out_free) begin
          cmd.emit_item = 1'b1;
          if (stat.last_step) begin
            state_next = S_IDLE;
          end else begin
            cmd.step_inc = 1'b1;
            cmd.cur_sel  = blle_pkg::CUR_FWD;
          end
        end
      end
      S_EMIT: begin
        cmd.status = code;
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bounded_linked_list_engine.sv =====
// Top level of the bounded doubly linked list engine.
// Usage: an input item on s_* carries an operation (push front, push back,
// delete by value, clear, dump) and a value. Results leave on m_* as items
// of status and value, with m_tlast set on the final result of an operation.
// Every operation but dump gives one result; dump gives one result per entry
// from head to tail, or a single empty status for an empty list.
// Timing: one item is taken at a time. Push into a full store gives a full
// status; otherwise it allocates a slot and, unless the list was empty, then
// links it at the head or tail. Delete compares the head, then the tail, then
// walks the list from the head until a match or its end. Dump gives one result
// per cycle while the output is not stalled. The dump and the search step
// through the links at one slot read per cycle, since each read yields the
// address of the next slot. The last result sits in an output register, so the
// next item is taken while it waits. When the receiver stalls, a dump pauses in
// place and the other operations hold their result until the register is free.
// Reset empties the list at once: all slots free, head, tail and count zero.
module bounded_linked_list_engine #(
  parameter int CAPACITY = blle_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // Bits from low: op [2:0], value [34:3], zero pad [39:35].
  input  logic [blle_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // Bits from low: status [1:0], item [33:2], zero pad [39:34].
  output logic [blle_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tlast
);

  blle_pkg::blle_cmd_t  cmd;
  blle_pkg::blle_stat_t stat;

  blle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  blle_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // A result is loaded only when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_status || cmd.emit_item) |-> stat.out_free)
    else $error("result loaded into a busy output register");

  // At most one list update is commanded in a cycle.
  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push_alloc, cmd.push_link, cmd.del_head, cmd.del_tail,
              cmd.del_mid, cmd.clear}))
    else $error("conflicting list updates");

  // After an item is taken the engine is not ready for another in the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken twice in a row");

  // A push is never commanded into a full store.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push_alloc |-> !stat.full)
    else $error("slot allocated in a full store");

endmodule
